// ----- hdl/double_scale_by_power_of_two_defines.svh -----
// assertion macros for the scaling block
`ifndef DOUBLE_SCALE_BY_POWER_OF_TWO_DEFINES_SVH
`define DOUBLE_SCALE_BY_POWER_OF_TWO_DEFINES_SVH

// check a property on every clock edge outside reset
`define DSP2_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DSP2_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/dsp2_pkg.sv -----
`timescale 1ns / 1ps
package dsp2_pkg;
	localparam int FracBits = 52;
	localparam logic [10:0] ExpMax = 11'h7FF;
	localparam int QueueDepth = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DOMAIN = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] K_PASS = 3'd0;
	localparam logic [2:0] K_NAN = 3'd1;
	localparam logic [2:0] K_NORMAL = 3'd2;
	localparam logic [2:0] K_SUB = 3'd3;
	localparam logic [2:0] K_SUB_INF = 3'd4;
	localparam logic [2:0] K_SUB_ZERO = 3'd5;

	typedef struct packed {
		logic [63:0] value_bits;
		logic signed [31:0] scale_exponent;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_bits;
		logic [1:0] status;
	} out_word_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [2:0] kind;
		logic [63:0] x;
		logic signed [12:0] n;      // clamped scale, enough for all cases
		logic [5:0] top;            // msb position of subnormal fraction
	} cls_word_t;
endpackage

// ----- hdl/dsp2_front.sv -----
`timescale 1ns / 1ps
module dsp2_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input dsp2_pkg::in_word_t in_word,
	output logic out_valid,
	output dsp2_pkg::cls_word_t out_word
);
	logic [10:0] ef;
	logic [51:0] frac;
	logic [5:0] top;
	logic signed [12:0] n_clamp;
	dsp2_pkg::cls_word_t cls;

	assign ef = in_word.value_bits[62:52];
	assign frac = in_word.value_bits[51:0];

	always_comb begin
		top = 6'd0;
		for (int i = 0; i < 52; i++) begin
			if (frac[i]) top = 6'(i);
		end
	end

	// clamp n to a range where all outcomes stay the same
	always_comb begin
		if (in_word.scale_exponent > 32'sd4095) n_clamp = 13'sd4095;
		else if (in_word.scale_exponent < -32'sd4095) n_clamp = -13'sd4095;
		else n_clamp = 13'(in_word.scale_exponent);
	end

	always_comb begin
		cls.x = in_word.value_bits;
		cls.n = n_clamp;
		cls.top = top;
		priority if (ef == dsp2_pkg::ExpMax && frac != '0) cls.kind = dsp2_pkg::K_NAN;
		else if (ef == dsp2_pkg::ExpMax || in_word.value_bits[62:0] == '0)
			cls.kind = dsp2_pkg::K_PASS;
		else if (ef != '0) cls.kind = dsp2_pkg::K_NORMAL;
		else if (n_clamp > 13'sd1023) cls.kind = dsp2_pkg::K_SUB_INF;
		else if (n_clamp < -13'sd1022) cls.kind = dsp2_pkg::K_SUB_ZERO;
		else cls.kind = dsp2_pkg::K_SUB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid) out_word <= cls;
	end
endmodule

// ----- hdl/dsp2_queue.sv -----
`timescale 1ns / 1ps
module dsp2_queue #(
	parameter int Depth = dsp2_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dsp2_pkg::cls_word_t push_word,
	input logic pop,
	output logic not_empty,
	output logic full,
	output dsp2_pkg::cls_word_t head
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	dsp2_pkg::cls_word_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign full = cnt_q == (AW+1)'(Depth);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end
endmodule

// ----- hdl/dsp2_back.sv -----
`timescale 1ns / 1ps
module dsp2_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input dsp2_pkg::cls_word_t in_word,
	output logic strobe,
	output dsp2_pkg::out_word_t result
);
	logic sign;
	logic [10:0] ef;
	logic [51:0] frac;
	logic signed [13:0] e;
	logic signed [13:0] biased;
	logic [51:0] mant;
	logic [10:0] s;
	logic [51:0] q, rem_mask, rem, half;
	logic [52:0] q_r;
	dsp2_pkg::out_word_t r;

	assign sign = in_word.x[63];
	assign ef = in_word.x[62:52];
	assign frac = in_word.x[51:0];
	assign e = 14'(ef) + 14'(in_word.n);
	assign biased = 14'(in_word.top) + 14'(in_word.n) - 14'sd51;
	assign mant = frac << (6'd52 - in_word.top);
	// right shift for subnormal results, up to 1022 places
	assign s = (in_word.n < 0) ? 11'(-in_word.n) : 11'd0;
	assign q = (s > 11'd51) ? '0 : (frac >> s);
	assign rem_mask = (s > 11'd51) ? '1 : ((52'd1 << s) - 52'd1);
	assign rem = frac & rem_mask;
	assign half = (s == 11'd0 || s > 11'd52) ? '0 : (52'd1 << (s - 11'd1));

	always_comb begin
		q_r = {1'b0, q};
		if ((s > 11'd52) ? 1'b0 : ((rem > half) || (rem == half && q[0])))
			q_r = {1'b0, q} + 53'd1;
	end

	always_comb begin
		r.result_bits = in_word.x;
		r.status = dsp2_pkg::ST_OK;
		unique case (in_word.kind)
			dsp2_pkg::K_NAN: r.status = dsp2_pkg::ST_DOMAIN;
			dsp2_pkg::K_PASS: ;
			dsp2_pkg::K_NORMAL: begin
				if (e <= 0) begin
					r.result_bits = '0;
					r.status = dsp2_pkg::ST_RANGE;
				end else if (e >= 14'sd2047) begin
					r.result_bits = {sign, dsp2_pkg::ExpMax, 52'd0};
					r.status = dsp2_pkg::ST_RANGE;
				end else r.result_bits = {sign, e[10:0], frac};
			end
			dsp2_pkg::K_SUB_INF: r.result_bits = {sign, dsp2_pkg::ExpMax, 52'd0};
			dsp2_pkg::K_SUB_ZERO: r.result_bits = {sign, 63'd0};
			dsp2_pkg::K_SUB: begin
				if (biased >= 1) r.result_bits = {sign, biased[10:0], mant};
				else if (in_word.n >= 0)
					r.result_bits = {sign, 11'd0, frac << in_word.n[5:0]};
				else r.result_bits = {sign, 10'd0, q_r};
			end
			default: r.result_bits = in_word.x;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid) result <= r;
	end
endmodule

// ----- hdl/double_scale_by_power_of_two.sv -----
`timescale 1ns / 1ps
// channel   | signals                      | handshake
// input     | start, busy, in_word         | taken when start && !busy
// result    | strobe, result               | shown one cycle, no back pressure
// an item passes from start to strobe through front classify, queue and back
// one item is accepted every cycle while busy is low; the back unit never stalls
// busy only rises if the queue fills, which the steady flow never does
// reset clears the valid flags, queue pointers and queue count; the data registers are not reset
module double_scale_by_power_of_two #(
	parameter int QueueDepth = dsp2_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input dsp2_pkg::in_word_t in_word,
	output logic strobe,
	output dsp2_pkg::out_word_t result
);
	logic f_valid, q_ne, q_full;
	dsp2_pkg::cls_word_t f_word, q_head;

	assign busy = q_full;

	dsp2_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .in_word(in_word),
		.out_valid(f_valid), .out_word(f_word)
	);

	dsp2_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .push_word(f_word),
		.pop(q_ne), .not_empty(q_ne), .full(q_full), .head(q_head)
	);

	dsp2_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_ne), .in_word(q_head),
		.strobe(strobe), .result(result)
	);
endmodule

// ----- hdl/dsp2_checker.sv -----
`timescale 1ns / 1ps
`include "double_scale_by_power_of_two_defines.svh"
module dsp2_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input dsp2_pkg::out_word_t result
);
	`DSP2_ASSERT(a_lat, clk, arst_n, (start && !busy) |-> ##3 strobe, "result missing")
	`DSP2_ASSERT(a_nospur, clk, arst_n, strobe |-> $past(start && !busy, 3), "spurious result")
	`DSP2_ASSERT(a_status, clk, arst_n, strobe |-> (result.status != 2'd3), "bad status")
	`DSP2_ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !strobe, "strobe in reset")
endmodule

bind double_scale_by_power_of_two dsp2_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .result(result)
);

// ----- tb/sv/tb_double_scale_by_power_of_two.sv -----
`timescale 1ns / 1ps
module tb_double_scale_by_power_of_two;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	dsp2_pkg::in_word_t in_word;
	logic strobe;
	dsp2_pkg::out_word_t result;

	double_scale_by_power_of_two dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_word(in_word),
		.strobe(strobe),
		.result(result)
	);

	dsp2_pkg::in_word_t pending_words[$];
	dsp2_pkg::out_word_t scaled_expected[$];
	int err_count = 0;
	int send_idle_pct = 0;
	longint cycle_count = 0;

	localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
	localparam logic [63:0] FracMask = 64'h000F_FFFF_FFFF_FFFF;
	localparam longint CycleLimit = 200000;

	function automatic dsp2_pkg::out_word_t scale_value(dsp2_pkg::in_word_t w);
		dsp2_pkg::out_word_t r;
		logic [63:0] x;
		logic [63:0] sgn;
		logic [10:0] ef;
		logic [63:0] f;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		longint n;
		longint e;
		longint biased;
		int top;
		x = w.value_bits;
		n = longint'(w.scale_exponent);
		sgn = x & SignBit;
		ef = x[62:52];
		f = x & FracMask;
		r.status = dsp2_pkg::ST_OK;
		if (ef == dsp2_pkg::ExpMax && f != 0) begin
			r.result_bits = x;
			r.status = dsp2_pkg::ST_DOMAIN;
		end else if (ef == dsp2_pkg::ExpMax || x[62:0] == 0) begin
			r.result_bits = x;
		end else if (ef == 0) begin
			if (n > 1023) begin
				r.result_bits = sgn | {1'b0, dsp2_pkg::ExpMax, 52'd0};
			end else if (n < -1022) begin
				r.result_bits = sgn;
			end else begin
				top = 0;
				for (int i = 0; i < 52; i++)
					if (f[i]) top = i;
				biased = top + n - 51;
				if (biased >= 1) begin
					q = (f << (dsp2_pkg::FracBits - top)) & FracMask;
					r.result_bits = sgn | (64'(biased) << dsp2_pkg::FracBits) | q;
				end else if (n >= 0) begin
					r.result_bits = sgn | (f << n);
				end else if (-n >= 64) begin
					r.result_bits = sgn;
				end else begin
					q = f >> (-n);
					rem = f & ((64'd1 << (-n)) - 1);
					half = 64'd1 << (-n - 1);
					if (rem > half || (rem == half && q[0])) q = q + 1;
					r.result_bits = sgn | q;
				end
			end
		end else begin
			e = longint'(ef) + n;
			if (e <= 0) begin
				r.result_bits = 64'd0;
				r.status = dsp2_pkg::ST_RANGE;
			end else if (e >= 2047) begin
				r.result_bits = sgn | {1'b0, dsp2_pkg::ExpMax, 52'd0};
				r.status = dsp2_pkg::ST_RANGE;
			end else begin
				r.result_bits = sgn | (64'(e) << dsp2_pkg::FracBits) | f;
			end
		end
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			in_word <= '0;
		end else begin
			if (start && !busy) scaled_expected.push_back(scale_value(in_word));
			if (!(start && busy)) begin
				if (pending_words.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					start <= 1;
					in_word <= pending_words.pop_front();
				end else begin
					start <= 0;
					in_word <= {$urandom, $urandom, $urandom};
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && strobe) begin
			if (scaled_expected.size() == 0) begin
				$error("unexpected word: result_bits %h status %0d",
					result.result_bits, result.status);
				err_count++;
			end else begin
				dsp2_pkg::out_word_t exp_w;
				exp_w = scaled_expected.pop_front();
				if (result.result_bits !== exp_w.result_bits) begin
					$error("result_bits expected %h actual %h",
						exp_w.result_bits, result.result_bits);
					err_count++;
				end
				if (result.status !== exp_w.status) begin
					$error("status expected %0d actual %0d", exp_w.status, result.status);
					err_count++;
				end
			end
		end
		if (cycle_count > CycleLimit) begin
			$display("tb_double_scale_by_power_of_two: done, errors");
			$finish;
		end
	end

	function automatic logic [63:0] rand_double();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(9))
			0: x[62:52] = 11'd0;
			1: x[62:52] = dsp2_pkg::ExpMax;
			2: x[62:0] = 63'd0;
			3: x[62:52] = 11'($urandom_range(1, 3));
			4: x[62:52] = 11'($urandom_range(2044, 2046));
			5: x[51:0] = 52'($urandom_range(7)) << $urandom_range(49);
			default: ;
		endcase
		return x;
	endfunction

	function automatic logic signed [31:0] rand_scale();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed(32'($urandom_range(2200))) - 1100;
			2: return $signed(32'($urandom_range(130))) - 65;
			3: return $signed(32'($urandom_range(2200))) - 2200;
			default: return $signed(32'($urandom_range(4200))) - 2100;
		endcase
	endfunction

	task automatic add_word(logic [63:0] x, logic signed [31:0] n);
		dsp2_pkg::in_word_t w;
		w.value_bits = x;
		w.scale_exponent = n;
		pending_words.push_back(w);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || scaled_expected.size() > 0 || start)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		in_word = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed: nan, infinities, zeros, normal edges, subnormal rounding
		add_word(64'h7FF8_0000_0000_0001, 5);
		add_word(64'hFFF0_0000_0000_0001, 32'sh8000_0000);
		add_word(64'h7FF0_0000_0000_0000, 100);
		add_word(64'hFFF0_0000_0000_0000, -100);
		add_word(64'h0000_0000_0000_0000, 32'sh7FFF_FFFF);
		add_word(64'h8000_0000_0000_0000, -3);
		add_word(64'h3FF0_0000_0000_0000, -1023);
		add_word(64'hBFF0_0000_0000_0000, -1022);
		add_word(64'hBFF0_0000_0000_0000, 1024);
		add_word(64'h3FFF_FFFF_FFFF_FFFF, 1023);
		add_word(64'h7FEF_FFFF_FFFF_FFFF, 32'sh8000_0000);
		add_word(64'h0010_0000_0000_0000, 32'sh7FFF_FFFF);
		add_word(64'h8000_0000_0000_0001, 1024);
		add_word(64'h800F_FFFF_FFFF_FFFF, 1023);
		add_word(64'h0000_0000_0000_0001, -1023);
		add_word(64'h8000_0000_0000_0003, -1022);
		add_word(64'h0000_0000_0000_0003, -1);
		add_word(64'h0000_0000_0000_0005, -1);
		add_word(64'h0000_0000_0000_0006, -2);
		add_word(64'h000F_FFFF_FFFF_FFFF, 1);
		add_word(64'h0000_0000_0000_0001, 52);
		add_word(64'h000F_FFFF_FFFF_FFFF, -60);
		add_word(64'h0000_0000_0000_0003, -100);
		add_word(64'h000F_FFFF_FFFF_FFFF, -64);
		add_word(64'hFFFF_FFFF_FFFF_FFFF, 0);
		// hold off until every expected word has come back
		drain();
		for (int i = 0; i < 1330; i++) begin
			if (i % 333 == 0) begin
				drain();
				send_idle_pct = (i / 333 == 1) ? 0 : ((i / 333 == 2) ? 48 : 18);
			end
			add_word(rand_double(), rand_scale());
		end
		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_double_scale_by_power_of_two: done, clean");
		end else begin
			$display("tb_double_scale_by_power_of_two: done, errors");
		end
		$finish;
	end
endmodule
